@@ src/gcl_pkg.sv @@
// shared types and constants of the glyph cache lookup block
package gcl_pkg;

   localparam int SLOTS_PER_SET = 250;
   localparam int FONT_SETS     = 12;
   localparam int ENTRIES       = SLOTS_PER_SET * FONT_SETS;
   localparam int ENTRY_AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SLOT_AW       = $clog2(SLOTS_PER_SET);
   localparam int SLOT_CW       = $clog2(SLOTS_PER_SET + 1);
   localparam int SET_W         = 4;
   localparam int SLOT_OUT_W    = 8;
   localparam int STAMP_W       = 31;
   localparam logic [STAMP_W-1:0] STAMP_MAX = 31'h7fffffff;

   typedef struct packed {
      logic [SET_W-1:0] font_set;
      logic [31:0]      glyph_hash;
      logic [15:0]      glyph_width;
      logic [15:0]      glyph_height;
      logic signed [15:0] glyph_offset;
      logic signed [15:0] glyph_baseline;
   } gcl_req_type;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot_index;
      logic                  was_hit;
   } gcl_rsp_type;

   typedef struct packed {
      logic [31:0] hash;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] offset;
      logic [15:0] baseline;
   } gcl_tag_type;

   typedef struct packed {
      gcl_tag_type        tag;
      logic [STAMP_W-1:0] stamp;
   } gcl_entry_type;

   typedef struct packed {
      logic               done;
      logic               hit;
      logic [SLOT_AW-1:0] slot;
   } gcl_scan_status_type;

   typedef enum logic [1:0] {
      GCL_CLEAR,
      GCL_IDLE,
      GCL_SCAN,
      GCL_WRITE
   } gcl_state_type;

endpackage

@@ src/gcl_ram.sv @@
// simple dual port synchronous ram, one write and one registered read port
module gcl_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16,
     localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/gcl_scan.sv @@
// set scanner: issues one read per cycle, matches tags and tracks the oldest stamp
module gcl_scan
   import gcl_pkg::*;
   (input  logic                clock,
    input  logic                reset,
    input  logic                start,
    input  gcl_tag_type         key,
    input  gcl_entry_type       rd_entry,
    output logic                rd_en,
    output logic [SLOT_AW-1:0]  rd_slot,
    output gcl_scan_status_type status);

   logic               active_ff, active_in;
   logic [SLOT_CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [SLOT_AW-1:0] chk_slot_ff, chk_slot_in;
   logic [STAMP_W-1:0] oldest_ff, oldest_in;
   logic [SLOT_AW-1:0] victim_ff, victim_in;

   logic hit_now;
   logic last_now;
   logic older;
   logic done;
   logic [SLOT_AW-1:0] victim_now;

   always_comb begin
      rd_en      = active_ff && (rd_cnt_ff < SLOT_CW'(SLOTS_PER_SET));
      rd_slot    = rd_cnt_ff[SLOT_AW-1:0];
      hit_now    = chk_valid_ff && (rd_entry.tag == key);
      last_now   = chk_valid_ff && (chk_slot_ff == SLOT_AW'(SLOTS_PER_SET - 1));
      older      = chk_valid_ff && (rd_entry.stamp < oldest_ff);
      victim_now = older ? chk_slot_ff : victim_ff;
      done       = active_ff && (hit_now || last_now);

      status.done = done;
      status.hit  = hit_now;
      status.slot = hit_now ? chk_slot_ff : victim_now;

      active_in    = active_ff;
      rd_cnt_in    = rd_cnt_ff;
      chk_valid_in = rd_en;
      chk_slot_in  = rd_slot;
      oldest_in    = older ? rd_entry.stamp : oldest_ff;
      victim_in    = victim_now;

      if (rd_en) begin
         rd_cnt_in = rd_cnt_ff + SLOT_CW'(1);
      end
      if (done) begin
         active_in    = 1'b0;
         chk_valid_in = 1'b0;
      end
      if (start) begin
         active_in    = 1'b1;
         rd_cnt_in    = '0;
         chk_valid_in = 1'b0;
         oldest_in    = STAMP_MAX;
         victim_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff   <= rd_cnt_in;
      chk_slot_ff <= chk_slot_in;
      oldest_ff   <= oldest_in;
      victim_ff   <= victim_in;
   end

endmodule

@@ src/glyph_cache_lru_lookup.sv @@
// top level of the glyph cache lookup: control, use counter and result register
//
// glyph cache lookup with least recently used replacement. every table entry of
// every font set (tags plus a 31-bit use stamp) lives in one synchronous ram.
// after reset the block runs a clearing pass that writes zero into all
// FONT_SETS * SLOTS_PER_SET entries, one per cycle; req_stall stays high
// during that pass. a lookup beat is then taken while the block is idle.
// the set's entries are read one per cycle through the ram's read port and
// checked in the cycle after, so a scan ends at the first hit or after the
// last slot of the set; the write state then writes the chosen entry back
// with a fresh stamp and loads the result register once it is free, and the
// block returns to idle, where the next beat can be taken. a full miss thus
// walks the whole set through the single read port. one lookup is in
// flight at a time; a result that is waiting on rsp_stall holds the
// write-back until it leaves, while a new lookup may already be scanning.
// font_set values past the last set are served by the last set. the use
// counter sticks at 2^31-1.
module glyph_cache_lru_lookup
   import gcl_pkg::*;
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_stall,
    input  gcl_req_type req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output gcl_rsp_type rsp_data);

   gcl_state_type state_ff, state_in;

   // clearing pass address
   logic [ENTRY_AW-1:0] clr_addr_ff, clr_addr_in;

   // lookup context held through the scan
   logic [ENTRY_AW-1:0] base_ff, base_in;
   gcl_tag_type         key_ff, key_in;
   logic [SLOT_AW-1:0]  res_slot_ff, res_slot_in;
   logic                res_hit_ff, res_hit_in;

   // global use counter
   logic [STAMP_W-1:0]  counter_ff, counter_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   gcl_rsp_type         rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                out_free;
   logic [SET_W-1:0]    set_sat;
   logic [STAMP_W-1:0]  bumped;

   // ram ports
   logic                wr_en;
   logic [ENTRY_AW-1:0] wr_addr;
   gcl_entry_type       wr_entry;
   logic                rd_en;
   logic [ENTRY_AW-1:0] rd_addr;
   gcl_entry_type       rd_entry;

   // scanner
   logic                scan_start;
   logic [SLOT_AW-1:0]  rd_slot;
   gcl_scan_status_type scan_status;

   assign req_stall = (state_ff != GCL_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // out of range font sets fold onto the last set
   always_comb begin
      if ({1'b0, req_data.font_set} >= (SET_W + 1)'(FONT_SETS)) begin
         set_sat = SET_W'(FONT_SETS - 1);
      end else begin
         set_sat = req_data.font_set;
      end
   end

   // saturating bump
   assign bumped = (counter_ff == STAMP_MAX) ? counter_ff : counter_ff + STAMP_W'(1);

   assign rd_addr    = base_ff + ENTRY_AW'(rd_slot);
   assign scan_start = req_fire;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      base_in      = base_ff;
      key_in       = key_ff;
      res_slot_in  = res_slot_ff;
      res_hit_in   = res_hit_ff;
      counter_in   = counter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_entry     = '0;

      unique case (state_ff)
         GCL_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + ENTRY_AW'(1);
            if (clr_addr_ff == ENTRY_AW'(ENTRIES - 1)) begin
               state_in = GCL_IDLE;
            end
         end
         GCL_IDLE: begin
            if (req_fire) begin
               base_in         = ENTRY_AW'(ENTRY_AW'(set_sat) * ENTRY_AW'(SLOTS_PER_SET));
               key_in.hash     = req_data.glyph_hash;
               key_in.width    = req_data.glyph_width;
               key_in.height   = req_data.glyph_height;
               key_in.offset   = req_data.glyph_offset;
               key_in.baseline = req_data.glyph_baseline;
               state_in        = GCL_SCAN;
            end
         end
         GCL_SCAN: begin
            if (scan_status.done) begin
               res_slot_in = scan_status.slot;
               res_hit_in  = scan_status.hit;
               state_in    = GCL_WRITE;
            end
         end
         GCL_WRITE: begin
            // write back tags and a fresh stamp once the result register is free
            wr_addr        = base_ff + ENTRY_AW'(res_slot_ff);
            wr_entry.tag   = key_ff;
            wr_entry.stamp = bumped;
            if (out_free) begin
               wr_en                  = 1'b1;
               counter_in             = bumped;
               rsp_valid_in           = 1'b1;
               rsp_data_in.slot_index = SLOT_OUT_W'(res_slot_ff);
               rsp_data_in.was_hit    = res_hit_ff;
               state_in               = GCL_IDLE;
            end
         end
         default: begin
            state_in = GCL_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= GCL_CLEAR;
         clr_addr_ff  <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      key_ff      <= key_in;
      res_slot_ff <= res_slot_in;
      res_hit_ff  <= res_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   gcl_ram #(
      .WIDTH ($bits(gcl_entry_type)),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   gcl_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .key      (key_in),
      .rd_entry (rd_entry),
      .rd_en    (rd_en),
      .rd_slot  (rd_slot),
      .status   (scan_status)
   );

endmodule

@@ dv/tb.sv @@
// testbench for the glyph cache lookup: directed and random lookups checked against a shadow table
`timescale 1ns / 1ps

module tb;
   import gcl_pkg::*;

   // set that gets filled past capacity so that replacement order matters
   localparam int LRU_SET   = 4;
   // quiet cycles after the last result: a bit more than one full miss scan
   localparam int TAIL_WAIT = 300;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   gcl_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   gcl_rsp_type rsp_data;

   // shadow copy of every table entry and of the shared use counter
   gcl_tag_type        shadow_tag   [ENTRIES];
   logic [STAMP_W-1:0] shadow_stamp [ENTRIES];
   logic [STAMP_W-1:0] shadow_clock = '0;

   gcl_rsp_type expected_slots [$];   // one per accepted lookup, oldest first
   gcl_req_type lru_glyphs     [$];   // glyphs looked up in the replacement set
   gcl_req_type seen_glyphs    [$];   // every glyph looked up so far

   int mismatches = 0;
   bit gaps_on    = 1'b1;             // sender idles in bursts
   bit stalls_on  = 1'b1;             // receiver stalls in bursts
   int hold_left  = 0;                // long receiver hold-off, in cycles
   int burst_left = 0;

   glyph_cache_lru_lookup i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data));

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // generous bound on the whole run
   initial begin
      #12_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      foreach (shadow_tag[i]) begin
         shadow_tag[i]   = '0;
         shadow_stamp[i] = '0;
      end
   end

   // works out slot and hit flag of one lookup and updates the shadow table;
   // the scan stops at the first full tag match, otherwise it keeps the
   // lowest-index entry with the smallest stamp below the maximum
   function automatic gcl_rsp_type predict_slot(input gcl_req_type r);
      int                 set_no;
      int                 base_e;
      int                 e;
      int                 slot;
      int                 victim;
      logic [STAMP_W-1:0] oldest;
      gcl_tag_type        key;
      gcl_rsp_type        res;
      bit                 found;
      // font sets past the last one fold onto the last table
      if (r.font_set >= FONT_SETS) set_no = FONT_SETS - 1;
      else set_no = int'(r.font_set);
      base_e = set_no * SLOTS_PER_SET;
      // offset and baseline compare as raw bit patterns
      key = '{hash: r.glyph_hash, width: r.glyph_width, height: r.glyph_height,
              offset: r.glyph_offset, baseline: r.glyph_baseline};
      found  = 1'b0;
      victim = 0;
      oldest = STAMP_MAX;
      slot   = 0;
      e      = base_e;
      while (!found && slot < SLOTS_PER_SET) begin
         e = base_e + slot;
         if (shadow_tag[e] == key) begin
            found = 1'b1;
         end else begin
            if (shadow_stamp[e] < oldest) begin
               oldest = shadow_stamp[e];
               victim = slot;
            end
            slot++;
         end
      end
      if (!found) begin
         e             = base_e + victim;
         shadow_tag[e] = key;
         slot          = victim;
      end
      // counter sticks at its maximum
      if (shadow_clock != STAMP_MAX) shadow_clock = shadow_clock + 1'b1;
      shadow_stamp[e] = shadow_clock;
      res.slot_index  = SLOT_OUT_W'(slot);
      res.was_hit     = found;
      return res;
   endfunction

   function automatic gcl_req_type make_glyph(input logic [SET_W-1:0] fs,
                                              input logic [31:0] hash,
                                              input logic [15:0] w, input logic [15:0] h,
                                              input logic [15:0] off, input logic [15:0] base);
      gcl_req_type r;
      r.font_set       = fs;
      r.glyph_hash     = hash;
      r.glyph_width    = w;
      r.glyph_height   = h;
      r.glyph_offset   = off;
      r.glyph_baseline = base;
      return r;
   endfunction

   // 16-bit field value leaning toward the corners of its range
   function automatic logic [15:0] pick_half();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h8000;
         3: return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic gcl_req_type rand_glyph(input logic [SET_W-1:0] fs);
      logic [31:0] hash;
      case ($urandom_range(0, 9))
         0: hash = 32'h0000_0000;
         1: hash = 32'hffff_ffff;
         default: hash = $urandom;
      endcase
      return make_glyph(fs, hash, pick_half(), pick_half(), pick_half(), pick_half());
   endfunction

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // offers one lookup beat and holds it until the block takes it; valid is
   // left high so that a following call can present the next beat at once
   task automatic offer_lookup(input gcl_req_type r);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_slots.push_back(predict_slot(r));
      seen_glyphs.push_back(r);
      if (r.font_set == LRU_SET) lru_glyphs.push_back(r);
   endtask

   // receiver: long hold-off when asked, otherwise random stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_stall  <= 1'b1;
            burst_left = $urandom_range(1, 8) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker: every accepted result beat against the oldest expectation
   always @(posedge clock) begin
      gcl_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_slots.size() == 0) begin
            report_mismatch($sformatf("result beat with no lookup pending, slot %0d hit %0b",
                                      rsp_data.slot_index, rsp_data.was_hit));
         end else begin
            want = expected_slots.pop_front();
            if (rsp_data.slot_index !== want.slot_index)
               report_mismatch($sformatf("slot_index %0d, expected %0d",
                                         rsp_data.slot_index, want.slot_index));
            if (rsp_data.was_hit !== want.was_hit)
               report_mismatch($sformatf("was_hit %b, expected %b",
                                         rsp_data.was_hit, want.was_hit));
         end
      end
   end

   // all-zero lookups match the zero tags left by reset
   task automatic test_zero_tags();
      offer_lookup(make_glyph(4'd0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      offer_lookup(make_glyph(4'd5, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
   endtask

   // field corners and near twins: misses fill set 1 in order, repeats hit
   task automatic test_field_extremes();
      gcl_req_type corner [5];
      corner[0] = make_glyph(4'd1, 32'hffff_ffff, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff);
      corner[1] = make_glyph(4'd1, 32'h0000_0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
      corner[2] = make_glyph(4'd1, 32'h8000_0000, 16'h8000, 16'h0001, 16'hffff, 16'h0001);
      corner[3] = make_glyph(4'd1, 32'hffff_ffff, 16'hffff, 16'hffff, 16'h7fff, 16'hffff);
      corner[4] = make_glyph(4'd1, 32'h0000_0000, 16'h0001, 16'h0000, 16'h8000, 16'h8000);
      foreach (corner[i]) offer_lookup(corner[i]);
      offer_lookup(corner[0]);
      offer_lookup(corner[1]);
      offer_lookup(corner[2]);
      // first never-written entry of set 1 still holds zero tags
      offer_lookup(make_glyph(4'd1, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
   endtask

   // font sets past the last one share the last table
   task automatic test_set_clamp();
      gcl_req_type g;
      gcl_req_type other;
      g     = rand_glyph(4'd11);
      other = rand_glyph(4'd13);
      offer_lookup(g);
      g.font_set = 4'd12;
      offer_lookup(g);
      g.font_set = 4'd15;
      offer_lookup(g);
      offer_lookup(other);
      other.font_set = 4'd11;
      offer_lookup(other);
   endtask

   // receiver holds off for a long stretch while quick hits keep coming, so
   // the result register fills and the block stalls its input
   task automatic test_pressure();
      gcl_req_type g;
      hold_left = 500;
      repeat (10) begin
         g = make_glyph(4'd1, 32'hffff_ffff, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff);
         if ($urandom_range(0, 1) == 1)
            g = make_glyph(4'd1, 32'h0000_0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
         offer_lookup(g);
      end
   endtask

   // fill the replacement set with distinct glyphs so later misses evict
   task automatic test_lru_fill();
      repeat (SLOTS_PER_SET) offer_lookup(rand_glyph(LRU_SET));
   endtask

   // mostly the full set: repeats of earlier glyphs (hits, or misses once
   // evicted) and new glyphs; the rest spread over all font set codes
   task automatic test_random_mix(input int count, input bit with_idle);
      gcl_req_type g;
      gaps_on   = with_idle;
      stalls_on = with_idle;
      repeat (count) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 99) < 55)
               g = lru_glyphs[$urandom_range(0, lru_glyphs.size() - 1)];
            else
               g = rand_glyph(LRU_SET);
         end else begin
            if ($urandom_range(0, 1) == 0)
               g = seen_glyphs[$urandom_range(0, seen_glyphs.size() - 1)];
            else
               g = rand_glyph(SET_W'($urandom_range(0, 15)));
         end
         offer_lookup(g);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // the clearing pass after reset shows up as req_stall on the first beat
      test_zero_tags();
      test_field_extremes();
      test_set_clamp();
      test_pressure();
      test_lru_fill();
      test_random_mix(420, 1'b1);
      test_random_mix(150, 1'b0);

      req_valid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/gcl_pkg.sv
src/gcl_ram.sv
src/gcl_scan.sv
src/glyph_cache_lru_lookup.sv
dv/tb.sv
